// ===== design/rgei_pkg.sv =====
// Package for the random graph edge inserter.
// Holds the beat payload types, status and mode codes, register indexes and FSM states.
// No dependencies.
package rgei_pkg;

	localparam int NODE_W      = 8;
	localparam int SLOT_IN_W   = 5;
	localparam int DEGREE_O_W  = 6;
	localparam int EDGE_W      = 13;
	localparam int COUNT_W     = 9;
	localparam int CFG_IDX_W   = 1;
	localparam int CFG_DATA_W  = 13;

	localparam logic [CFG_IDX_W-1:0] CFG_NODE_COUNT   = 1'b0;
	localparam logic [CFG_IDX_W-1:0] CFG_TARGET_EDGES = 1'b1;

	localparam logic [COUNT_W-1:0] NODE_COUNT_RESET = 9'd256;
	localparam logic [EDGE_W-1:0]  TARGET_RESET     = 13'd0;

	typedef enum logic [0:0] {
		MODE_PROPOSE = 1'b0,
		MODE_READ    = 1'b1
	} mode_t;

	typedef enum logic [2:0] {
		STAT_OK     = 3'd0,
		STAT_SELF   = 3'd1,
		STAT_DUP    = 3'd2,
		STAT_TARGET = 3'd3,
		STAT_FULL   = 3'd4,
		STAT_RANGE  = 3'd5
	} status_t;

	typedef enum logic [2:0] {
		S_CLEAR,
		S_IDLE,
		S_FETCH,
		S_EVAL,
		S_COMMIT,
		S_DONE
	} state_t;

	typedef struct packed {
		mode_t                mode;
		logic [NODE_W-1:0]    node_a;
		logic [NODE_W-1:0]    node_b;
		logic [SLOT_IN_W-1:0] slot;
	} req_t;

	typedef struct packed {
		status_t               status;
		logic [NODE_W-1:0]     neighbor;
		logic [DEGREE_O_W-1:0] degree;
		logic [EDGE_W-1:0]     edge_total;
		logic                  done_res;
	} rsp_t;

endpackage

// ===== design/rgei_stream_if.sv =====
// Valid/ready stream channel for the random graph edge inserter.
// The payload type is a parameter; the block uses the structs of rgei_pkg.
interface rgei_stream_if #(
	parameter type payload_t = logic
);

	logic     valid;
	logic     ready;
	payload_t payload;

	modport source (output valid, output payload, input ready);
	modport sink (input valid, input payload, output ready);

endinterface

// ===== design/random_graph_edge_inserter_core.sv =====
// Random graph edge inserter: a read beat returns one adjacency entry, a propose beat adds an edge.
// An item passes through the FETCH, EVAL, COMMIT (only when an edge is placed) and DONE states;
// no new item is accepted until its result is loaded into the output register, which waits while
// the previous result beat still waits for rsp.ready. The single read port of the degree memory
// reads node_a, then node_b. After reset the degree memory is swept to zero, during which no item
// is taken. The adjacency memory is not cleared. Depends on rgei_pkg and rgei_stream_if.
module random_graph_edge_inserter_core #(
	parameter int NODES      = 256,
	parameter int MAX_DEGREE = 32
) (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic                               wr_en,
	input  logic [rgei_pkg::CFG_IDX_W-1:0]     wr_index,
	input  logic [rgei_pkg::CFG_DATA_W-1:0]    wr_data,
	rgei_stream_if.sink                        req,
	rgei_stream_if.source                      rsp
);
	import rgei_pkg::*;

	localparam int ROW_W  = $clog2(NODES);
	localparam int SLOT_W = $clog2(MAX_DEGREE);
	localparam int DEG_W  = $clog2(MAX_DEGREE + 1);
	localparam logic [ROW_W-1:0] LAST_ROW = ROW_W'(NODES - 1);
	localparam logic [DEG_W-1:0] DEG_MAX  = DEG_W'(MAX_DEGREE);

	logic [NODE_W-1:0] adj_mem [NODES][MAX_DEGREE];
	logic [DEG_W-1:0]  deg_mem [NODES];

	state_t             state_q, state_d;
	logic [COUNT_W-1:0] node_count_q;
	logic [EDGE_W-1:0]  target_q;
	logic [EDGE_W-1:0]  edge_q;
	logic [ROW_W-1:0]   clr_idx_q;
	logic               out_valid_q;
	rsp_t               out_q;

	req_t               item_q;
	logic [NODE_W-1:0]  row_rd_q [MAX_DEGREE];
	logic [DEG_W-1:0]   deg_rd_q;
	logic [DEG_W-1:0]   deg_a_q;
	logic [DEG_W-1:0]   deg_b_q;
	logic               dup_q;
	logic [NODE_W-1:0]  nbr_q;
	status_t            res_status_q;
	logic [NODE_W-1:0]  res_nbr_q;
	logic [DEG_W-1:0]   res_deg_q;

	logic               req_fire;
	logic               out_load;
	logic [ROW_W-1:0]   deg_raddr;
	logic               deg_we;
	logic [ROW_W-1:0]   deg_waddr;
	logic [DEG_W-1:0]   deg_wdata;
	logic               adj_we;
	logic [ROW_W-1:0]   adj_wrow;
	logic [SLOT_W-1:0]  adj_wslot;
	logic [NODE_W-1:0]  adj_wdata;
	logic               dup_c;
	logic [NODE_W-1:0]  nbr_c;
	logic               a_ok;
	logic               b_ok;
	status_t            status_c;
	logic               place_c;
	logic [DEG_W-1:0]   deg_res_c;

	assign req_fire = req.valid && req.ready;

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			S_CLEAR: begin
				if (clr_idx_q == LAST_ROW) begin
					state_d = S_IDLE;
				end
			end
			S_IDLE: begin
				if (req_fire) begin
					state_d = S_FETCH;
				end
			end
			S_FETCH: state_d = S_EVAL;
			S_EVAL: begin
				state_d = place_c ? S_COMMIT : S_DONE;
			end
			S_COMMIT: state_d = S_DONE;
			S_DONE: begin
				if (out_load) begin
					state_d = S_IDLE;
				end
			end
			default: state_d = S_IDLE;
		endcase
	end

	always_comb begin
		req.ready = (state_q == S_IDLE);
		out_load  = (state_q == S_DONE) && (!out_valid_q || rsp.ready);
		deg_raddr = (state_q == S_FETCH) ? ROW_W'(item_q.node_b) : ROW_W'(req.payload.node_a);
		deg_we    = 1'b0;
		deg_waddr = clr_idx_q;
		deg_wdata = '0;
		adj_we    = 1'b0;
		adj_wrow  = ROW_W'(item_q.node_a);
		adj_wslot = SLOT_W'(deg_a_q);
		adj_wdata = item_q.node_b;
		unique case (state_q)
			S_CLEAR: begin
				deg_we = 1'b1;
			end
			S_EVAL: begin
				deg_we    = place_c;
				deg_waddr = ROW_W'(item_q.node_a);
				deg_wdata = DEG_W'(deg_a_q + 1'b1);
				adj_we    = place_c;
			end
			S_COMMIT: begin
				deg_we    = 1'b1;
				deg_waddr = ROW_W'(item_q.node_b);
				deg_wdata = DEG_W'(deg_b_q + 1'b1);
				adj_we    = 1'b1;
				adj_wrow  = ROW_W'(item_q.node_b);
				adj_wslot = SLOT_W'(deg_b_q);
				adj_wdata = item_q.node_a;
			end
			default: begin
			end
		endcase
	end

	// The whole row of node_a is checked against node_b at once, combinationally.
	always_comb begin
		dup_c = 1'b0;
		for (int i = 0; i < MAX_DEGREE; i++) begin
			if (i < int'(deg_rd_q) && row_rd_q[i] == item_q.node_b) begin
				dup_c = 1'b1;
			end
		end
		nbr_c = '0;
		if (item_q.mode == MODE_READ && 32'(item_q.slot) < 32'(deg_rd_q)
				&& 32'(item_q.slot) < MAX_DEGREE) begin
			nbr_c = row_rd_q[SLOT_W'(item_q.slot)];
		end
	end

	always_comb begin
		a_ok = (32'(item_q.node_a) < 32'(node_count_q)) && (32'(item_q.node_a) < NODES);
		b_ok = (32'(item_q.node_b) < 32'(node_count_q)) && (32'(item_q.node_b) < NODES);
		if (item_q.mode == MODE_PROPOSE) begin
			if (edge_q >= target_q) begin
				status_c = STAT_TARGET;
			end else if (!a_ok || !b_ok) begin
				status_c = STAT_RANGE;
			end else if (item_q.node_a == item_q.node_b) begin
				status_c = STAT_SELF;
			end else if (dup_q) begin
				status_c = STAT_DUP;
			end else if (deg_a_q >= DEG_MAX || deg_rd_q >= DEG_MAX) begin
				status_c = STAT_FULL;
			end else begin
				status_c = STAT_OK;
			end
		end else begin
			status_c = a_ok ? STAT_OK : STAT_RANGE;
		end
		place_c = (state_q == S_EVAL) && (item_q.mode == MODE_PROPOSE) && (status_c == STAT_OK);
		if (!a_ok) begin
			deg_res_c = '0;
		end else if (place_c) begin
			deg_res_c = DEG_W'(deg_a_q + 1'b1);
		end else begin
			deg_res_c = deg_a_q;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= S_CLEAR;
			node_count_q <= NODE_COUNT_RESET;
			target_q     <= TARGET_RESET;
			edge_q       <= '0;
			clr_idx_q    <= '0;
			out_valid_q  <= 1'b0;
		end else begin
			state_q <= state_d;
			if (wr_en) begin
				unique case (wr_index)
					CFG_NODE_COUNT:   node_count_q <= wr_data[COUNT_W-1:0];
					CFG_TARGET_EDGES: target_q <= wr_data[EDGE_W-1:0];
					default: begin
					end
				endcase
			end
			if (state_q == S_CLEAR) begin
				clr_idx_q <= ROW_W'(clr_idx_q + 1'b1);
			end
			if (place_c) begin
				edge_q <= EDGE_W'(edge_q + 1'b1);
			end
			if (out_load) begin
				out_valid_q <= 1'b1;
			end else if (rsp.ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		deg_rd_q <= deg_mem[deg_raddr];
		if (req_fire) begin
			row_rd_q <= adj_mem[ROW_W'(req.payload.node_a)];
		end
		if (deg_we) begin
			deg_mem[deg_waddr] <= deg_wdata;
		end
		if (adj_we) begin
			adj_mem[adj_wrow][adj_wslot] <= adj_wdata;
		end
	end

	always_ff @(posedge clk) begin
		if (req_fire) begin
			item_q <= req.payload;
		end
		if (state_q == S_FETCH) begin
			deg_a_q <= deg_rd_q;
			dup_q   <= dup_c;
			nbr_q   <= nbr_c;
		end
		if (state_q == S_EVAL) begin
			deg_b_q      <= deg_rd_q;
			res_status_q <= status_c;
			res_nbr_q    <= (status_c == STAT_OK) ? nbr_q : '0;
			res_deg_q    <= deg_res_c;
		end
		if (out_load) begin
			out_q.status     <= res_status_q;
			out_q.neighbor   <= res_nbr_q;
			out_q.degree     <= DEGREE_O_W'(res_deg_q);
			out_q.edge_total <= edge_q;
			out_q.done_res   <= (edge_q >= target_q);
		end
	end

	assign rsp.valid   = out_valid_q;
	assign rsp.payload = out_q;

`ifndef SYNTHESIS
	a_deg_bound: assert property (@(posedge clk) disable iff (!arst_n)
		deg_we |-> (deg_wdata <= DEG_MAX))
		else $error("degree write exceeds the row size");

	a_edge_step: assert property (@(posedge clk) disable iff (!arst_n)
		(edge_q != $past(edge_q)) |-> ($past(state_q) == S_EVAL
			&& edge_q == EDGE_W'($past(edge_q) + 1'b1)))
		else $error("edge counter changed outside an edge placement");

	a_rsp_source: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(rsp.valid) |-> ($past(state_q) == S_DONE))
		else $error("result beat raised outside the result state");
`endif

endmodule

// ===== verif/rgei_graph_checker.sv =====
// Scoreboard for the random graph edge inserter: watches the register port and both channels.
// Keeps its own copy of the graph, predicts one result per request beat and compares in order.
// Depends on rgei_pkg.
module rgei_graph_checker #(
	parameter int NODES      = 256,
	parameter int MAX_DEGREE = 32
) (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            wr_en,
	input  logic [rgei_pkg::CFG_IDX_W-1:0]  wr_index,
	input  logic [rgei_pkg::CFG_DATA_W-1:0] wr_data,
	input  logic                            req_valid,
	input  logic                            req_ready,
	input  rgei_pkg::req_t                  req_beat,
	input  logic                            rsp_valid,
	input  logic                            rsp_ready,
	input  rgei_pkg::rsp_t                  rsp_beat,
	output int                              mismatches,
	output int                              pending,
	output int                              edges_placed
);
	timeunit 1ns;
	timeprecision 1ps;

	import rgei_pkg::*;

	logic [COUNT_W-1:0] n_used;
	logic [EDGE_W-1:0]  edge_goal;
	logic [EDGE_W-1:0]  edges;
	int unsigned        deg_of [NODES];
	logic [NODE_W-1:0]  row_mem [NODES][MAX_DEGREE];
	rsp_t               expected_rsp_q [$];
	int                 fail_tally = 0;

	function automatic bit node_ok(int unsigned n);
		return (n < n_used) && (n < NODES);
	endfunction

	function automatic bit linked(int unsigned a, int unsigned b);
		for (int unsigned i = 0; i < deg_of[a] && i < MAX_DEGREE; i++) begin
			if (row_mem[a][i] == NODE_W'(b))
				return 1'b1;
		end
		return 1'b0;
	endfunction

	function automatic status_t try_insert(int unsigned a, int unsigned b);
		if (edges >= edge_goal)
			return STAT_TARGET;
		if (!node_ok(a) || !node_ok(b))
			return STAT_RANGE;
		if (a == b)
			return STAT_SELF;
		if (linked(a, b))
			return STAT_DUP;
		if (deg_of[a] >= MAX_DEGREE || deg_of[b] >= MAX_DEGREE)
			return STAT_FULL;
		row_mem[a][deg_of[a]] = NODE_W'(b);
		row_mem[b][deg_of[b]] = NODE_W'(a);
		deg_of[a]++;
		deg_of[b]++;
		edges = edges + 1'b1;
		return STAT_OK;
	endfunction

	function automatic rsp_t predict_graph_beat(req_t item);
		rsp_t        r;
		int unsigned a;
		int unsigned b;
		int unsigned s;
		a = 32'(item.node_a);
		b = 32'(item.node_b);
		s = 32'(item.slot);
		r.neighbor = '0;
		if (item.mode == MODE_PROPOSE) begin
			r.status = try_insert(a, b);
		end else if (!node_ok(a)) begin
			r.status = STAT_RANGE;
		end else begin
			r.status = STAT_OK;
			if (s < deg_of[a] && s < MAX_DEGREE)
				r.neighbor = row_mem[a][s];
		end
		r.degree     = node_ok(a) ? DEGREE_O_W'(deg_of[a]) : '0;
		r.edge_total = edges;
		r.done_res   = (edges >= edge_goal);
		return r;
	endfunction

	function automatic void check_field(string what, logic [31:0] want, logic [31:0] got);
		if (got !== want) begin
			fail_tally++;
			$display("%0t ns: %s mismatch, expected %0d, actual %0d", $time, what, want, got);
		end
	endfunction

	always @(posedge clk or negedge arst_n) begin : watch_channels
		rsp_t want;
		if (!arst_n) begin
			n_used    = NODE_COUNT_RESET;
			edge_goal = TARGET_RESET;
			edges     = '0;
			foreach (deg_of[i])
				deg_of[i] = 0;
			expected_rsp_q.delete();
		end else begin
			if (rsp_valid && rsp_ready) begin
				if (expected_rsp_q.size() == 0) begin
					fail_tally++;
					$display("%0t ns: result beat with nothing expected, expected none, actual %h",
						$time, rsp_beat);
				end else begin
					want = expected_rsp_q.pop_front();
					check_field("status", 32'(want.status), 32'(rsp_beat.status));
					check_field("neighbor", 32'(want.neighbor), 32'(rsp_beat.neighbor));
					check_field("degree", 32'(want.degree), 32'(rsp_beat.degree));
					check_field("edge_total", 32'(want.edge_total), 32'(rsp_beat.edge_total));
					check_field("done_res", 32'(want.done_res), 32'(rsp_beat.done_res));
				end
			end
			if (req_valid && req_ready)
				expected_rsp_q.push_back(predict_graph_beat(req_beat));
			if (wr_en) begin
				if (wr_index == CFG_NODE_COUNT)
					n_used = wr_data[COUNT_W-1:0];
				else if (wr_index == CFG_TARGET_EDGES)
					edge_goal = wr_data[EDGE_W-1:0];
			end
		end
		mismatches   <= fail_tally;
		pending      <= expected_rsp_q.size();
		edges_placed <= 32'(edges);
	end

endmodule

// ===== verif/tb_random_graph_edge_inserter_core.sv =====
// Top of the random graph edge inserter testbench: clock, reset, register writes and stimulus.
// Directed pairs and reads first, then random phases over several graph sizes and edge targets.
// Depends on rgei_pkg, rgei_stream_if, the core and rgei_graph_checker.
module tb_random_graph_edge_inserter_core;
	timeunit 1ns;
	timeprecision 1ps;

	import rgei_pkg::*;

	localparam int NODES          = 256;
	localparam int MAX_DEGREE     = 32;
	localparam int WATCHDOG_LIMIT = 2000;
	localparam int DRAIN_CYCLES   = 8;

	logic                  clk = 1'b0;
	logic                  arst_n;
	logic                  wr_en;
	logic [CFG_IDX_W-1:0]  wr_index;
	logic [CFG_DATA_W-1:0] wr_data;

	int mismatches;
	int pending;
	int edges_placed;
	int quiet_cycles = 0;
	int beats_sent = 0;
	int settings_used = 0;
	bit stalls_on = 1'b1;

	rgei_stream_if #(.payload_t(req_t)) req_if ();
	rgei_stream_if #(.payload_t(rsp_t)) rsp_if ();

	random_graph_edge_inserter_core #(
		.NODES      (NODES),
		.MAX_DEGREE (MAX_DEGREE)
	) DUT (
		.clk      (clk),
		.arst_n   (arst_n),
		.wr_en    (wr_en),
		.wr_index (wr_index),
		.wr_data  (wr_data),
		.req      (req_if),
		.rsp      (rsp_if)
	);

	rgei_graph_checker #(
		.NODES      (NODES),
		.MAX_DEGREE (MAX_DEGREE)
	) graph_checker (
		.clk          (clk),
		.arst_n       (arst_n),
		.wr_en        (wr_en),
		.wr_index     (wr_index),
		.wr_data      (wr_data),
		.req_valid    (req_if.valid),
		.req_ready    (req_if.ready),
		.req_beat     (req_if.payload),
		.rsp_valid    (rsp_if.valid),
		.rsp_ready    (rsp_if.ready),
		.rsp_beat     (rsp_if.payload),
		.mismatches   (mismatches),
		.pending      (pending),
		.edges_placed (edges_placed)
	);

	always begin
		#2 clk = 1'b1;
		#2 clk = 1'b0;
	end

	always @(posedge clk) begin
		if (arst_n) begin
			if ((req_if.valid && req_if.ready) || (rsp_if.valid && rsp_if.ready)) begin
				quiet_cycles <= 0;
			end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
				$display("[FAIL] regression broken");
				$finish;
			end else begin
				quiet_cycles <= quiet_cycles + 1;
			end
		end
	end

	initial begin : result_sink
		int stall;
		rsp_if.ready = 1'b0;
		wait (arst_n === 1'b1);
		forever begin
			stall = stalls_on ? $urandom_range(0, 3) : 0;
			if (stall > 0) begin
				rsp_if.ready <= 1'b0;
				repeat (stall) @(posedge clk);
			end
			rsp_if.ready <= 1'b1;
			do @(posedge clk); while (!rsp_if.valid);
		end
	end

	task automatic send_graph_beat(input req_t item);
		int gap;
		gap = stalls_on ? $urandom_range(0, 3) : 0;
		if (gap > 0) begin
			req_if.valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		req_if.valid   <= 1'b1;
		req_if.payload <= item;
		do @(posedge clk); while (!req_if.ready);
		beats_sent++;
	endtask

	task automatic offer_edge(input int a, input int b);
		req_t item;
		item.mode   = MODE_PROPOSE;
		item.node_a = a[NODE_W-1:0];
		item.node_b = b[NODE_W-1:0];
		item.slot   = SLOT_IN_W'($urandom);
		send_graph_beat(item);
	endtask

	task automatic peek_slot(input int a, input int s);
		req_t item;
		item.mode   = MODE_READ;
		item.node_a = a[NODE_W-1:0];
		item.node_b = NODE_W'($urandom);
		item.slot   = s[SLOT_IN_W-1:0];
		send_graph_beat(item);
	endtask

	task automatic finish_pending();
		req_if.valid <= 1'b0;
		@(posedge clk);
		while (pending != 0)
			@(posedge clk);
	endtask

	task automatic program_graph(input logic [CFG_DATA_W-1:0] nodes_word,
			input logic [CFG_DATA_W-1:0] goal);
		finish_pending();
		repeat (4) @(posedge clk);
		wr_en    <= 1'b1;
		wr_index <= CFG_NODE_COUNT;
		wr_data  <= nodes_word;
		@(posedge clk);
		wr_index <= CFG_TARGET_EDGES;
		wr_data  <= goal;
		@(posedge clk);
		wr_en <= 1'b0;
		settings_used++;
	endtask

	task automatic run_phase(input int count, input logic [CFG_DATA_W-1:0] nodes_word,
			input logic [CFG_DATA_W-1:0] goal, input int hub, input bit hubbed,
			input bit stalls);
		req_t item;
		int   span;
		int   pick;
		program_graph(nodes_word, goal);
		stalls_on = stalls;
		span = (int'(nodes_word[COUNT_W-1:0]) > NODES) ? NODES : int'(nodes_word[COUNT_W-1:0]);
		for (int i = 0; i < count; i++) begin
			// Halfway through, hold the sender until the block has answered everything so far.
			if (i == count / 2)
				finish_pending();
			pick        = $urandom_range(0, 99);
			item.mode   = MODE_PROPOSE;
			item.node_a = NODE_W'($urandom_range(0, span - 1));
			item.node_b = NODE_W'($urandom);
			item.slot   = SLOT_IN_W'($urandom);
			if (pick < 15) begin
				item.mode = MODE_READ;
			end else if (pick < 22) begin
				item.mode   = mode_t'($urandom_range(0, 1));
				item.node_a = NODE_W'($urandom);
			end else begin
				item.node_b = NODE_W'($urandom_range(0, span - 1));
				if (hubbed) begin
					if ($urandom_range(0, 1))
						item.node_a = hub[NODE_W-1:0];
					else
						item.node_b = hub[NODE_W-1:0];
				end
			end
			send_graph_beat(item);
		end
	endtask

	initial begin : stimulus
		arst_n         = 1'b0;
		wr_en          = 1'b0;
		wr_index       = CFG_NODE_COUNT;
		wr_data        = '0;
		req_if.valid   = 1'b0;
		req_if.payload = '0;
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;

		// With the reset target of zero the graph counts as complete from the start.
		offer_edge(0, 1);
		peek_slot(255, 31);

		program_graph(13'd256, 13'd4096);
		offer_edge(0, 255);
		offer_edge(255, 0);
		offer_edge(7, 7);
		offer_edge(0, 0);
		peek_slot(0, 0);
		peek_slot(0, 1);
		peek_slot(255, 31);
		offer_edge(255, 128);
		peek_slot(255, 1);

		// Upper data bits above the node count field must be dropped.
		program_graph(13'h1E05, 13'd3);
		offer_edge(5, 1);
		offer_edge(1, 200);
		peek_slot(5, 0);
		offer_edge(1, 2);
		offer_edge(3, 4);
		offer_edge(9, 9);

		program_graph(13'd1, 13'd4096);
		offer_edge(0, 1);
		peek_slot(0, 0);

		program_graph(13'd0, 13'd4096);
		peek_slot(0, 0);
		offer_edge(0, 0);

		program_graph(13'h01FF, 13'd4096);
		offer_edge(254, 255);
		peek_slot(255, 2);

		run_phase(110, 13'd64, 13'd4096, 0, 1'b1, 1'b1);
		finish_pending();
		run_phase(120, 13'd256, 13'(edges_placed + 40), 0, 1'b0, 1'b0);
		run_phase(40, 13'd2, 13'd4096, 0, 1'b0, 1'b1);
		run_phase(130, 13'h1F00, 13'h1FFF, 200, 1'b1, 1'b1);
		finish_pending();
		run_phase(60, 13'($urandom_range(2, 256)), 13'(edges_placed + $urandom_range(0, 30)),
			0, 1'b0, 1'($urandom_range(0, 1)));

		finish_pending();
		repeat (DRAIN_CYCLES) @(posedge clk);
		$display("Covered %0d request beats across %0d register settings, %0d edges in the graph.",
			beats_sent, settings_used, edges_placed);
		$display("Node counts from 0 to 511, targets from 0 to 8191, hub runs up to full lists.");
		if (mismatches == 0 && pending == 0) begin
			$display("[ OK ] regression clean");
		end else begin
			$display("[FAIL] regression broken");
		end
		$finish;
	end

endmodule
